/* src/websocket_frame_deframer_macros.svh */
// Assertion macros for the WebSocket deframer.
// Needs nothing else; included by the top level only.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Implication checked in the same cycle, masked while reset is applied.
`define WFD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define WFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wfd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wfd_step and websocket_frame_deframer.
`default_nettype none

package wfd_pkg;

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_HDR1    = 7'b0000010,
        PH_EXT_HI  = 7'b0000100,
        PH_EXT_LO  = 7'b0001000,
        PH_KEY     = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_BAD_OP  = 2'd2;
    localparam logic [1:0] KIND_LEN64   = 2'd3;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] OPCODE_RESET = 4'd1;

    // Register index of the opcode register on the APB port.
    localparam logic REG_ACCEPTED_OPCODE = 1'b0;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] frame_length;
        logic [15:0] payload_index;
        logic [31:0] mask_key;      // first key byte in [31:24]
        logic        mask_present;
        logic [1:0]  key_count;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       last_byte;
        logic [1:0] result_kind;
    } result_t;

endpackage

`default_nettype wire

/* src/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: APB opcode register,
// parser state, output register. Uses wfd_pkg, wfd_step and the macro header.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  s_tdata = stream_byte, s_tuser = restart
//   m_        out  m_tvalid/m_tready  m_tdata = payload_byte, m_tlast = last_byte,
//                                     m_tuser = result_kind
//   APB       in   psel/penable       accepted_opcode at byte address 0
//
// One word per cycle while s_tready is high. A word's state update and its result
// are formed in the cycle it is accepted and land in the output register in the next cycle.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled m_ side holds back at most one finished result.
// Reset (aresetn low, synchronous) sets the parser idle and the opcode to 1.
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // received byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  wire logic [0:0]  s_tuser,   // [0] restart
    // decoded payload / status
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload_byte
    output logic             m_tlast,   // last_byte
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0]            opcode_reg;
    logic [3:0]            opcode_next;
    wfd_pkg::parse_state_t state_reg;
    wfd_pkg::parse_state_t state_next;
    wfd_pkg::parse_state_t step_state;
    wfd_pkg::result_t      step_result;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;
    logic [1:0]            out_kind_reg;
    logic                  s_fire;
    logic                  out_load;
    logic                  cfg_write;

    // ------------------------------------------------------------------
    // APB register: the user must write it only while the stream is quiet; the block does not enforce this.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready
                     & (paddr[2] == wfd_pkg::REG_ACCEPTED_OPCODE);
    assign prdata    = (paddr[2] == wfd_pkg::REG_ACCEPTED_OPCODE) ? {28'd0, opcode_reg} : 32'd0;

    always_comb begin
        opcode_next = opcode_reg;
        if (cfg_write) begin
            opcode_next = pwdata[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the output register decouples the two sides.
    // ------------------------------------------------------------------
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = s_fire && step_result.valid;

    wfd_step u_step (
        .cur_state       (state_reg),
        .stream_byte     (s_tdata),
        .restart         (s_tuser[0]),
        .accepted_opcode (opcode_reg),
        .nxt_state       (step_state),
        .result          (step_result)
    );

    assign state_next = s_fire ? step_state : state_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcode_reg              <= wfd_pkg::OPCODE_RESET;
            state_reg.phase         <= wfd_pkg::PH_IDLE;
            state_reg.frame_length  <= '0;
            state_reg.payload_index <= '0;
            state_reg.mask_key      <= '0;
            state_reg.mask_present  <= 1'b0;
            state_reg.key_count     <= '0;
            out_valid_reg           <= 1'b0;
        end else begin
            opcode_reg    <= opcode_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg <= step_result.payload_byte;
            out_last_reg <= step_result.last_byte;
            out_kind_reg <= step_result.result_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WFD_ASSERT_SAME(a_reject_clean, aclk, aresetn,
        m_tvalid && (m_tuser == wfd_pkg::KIND_BAD_OP || m_tuser == wfd_pkg::KIND_LEN64),
        !m_tlast && m_tdata == 8'd0, "rejection result carries data or last")
    `WFD_ASSERT_NEXT(a_done_after_last, aclk, aresetn,
        out_load && step_result.last_byte,
        state_reg.phase == wfd_pkg::PH_DONE, "parser not finished after last result")
    `WFD_ASSERT_SAME(a_key_needs_mask, aclk, aresetn,
        state_reg.phase == wfd_pkg::PH_KEY,
        state_reg.mask_present, "collecting key for unmasked frame")
    `WFD_ASSERT_SAME(a_ready_when_empty, aclk, aresetn,
        !out_valid_reg, s_tready, "input stalled with empty output register")

endmodule

`default_nettype wire

/* src/wfd_step.sv */
// Next-state and result logic of the deframer for one received word.
// Uses wfd_pkg; instantiated by websocket_frame_deframer.
`default_nettype none

module wfd_step (
    input  wire wfd_pkg::parse_state_t cur_state,
    input  wire logic [7:0]            stream_byte,
    input  wire logic                  restart,
    input  wire logic [3:0]            accepted_opcode,
    output wfd_pkg::parse_state_t      nxt_state,
    output wfd_pkg::result_t           result
);

    logic        len_done;
    logic        hdr_done;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic [15:0] index_inc;

    always_comb begin
        nxt_state = cur_state;
        result    = '0;
        len_done  = 1'b0;
        hdr_done  = 1'b0;
        len7      = stream_byte[6:0];
        index_inc = cur_state.payload_index + 16'd1;
        key_byte  = 8'd0;

        if (restart) begin
            nxt_state.frame_length  = '0;
            nxt_state.payload_index = '0;
            nxt_state.mask_key      = '0;
            nxt_state.mask_present  = 1'b0;
            nxt_state.key_count     = '0;
            if (stream_byte[3:0] != accepted_opcode) begin
                nxt_state.phase    = wfd_pkg::PH_DONE;
                result.valid       = 1'b1;
                result.result_kind = wfd_pkg::KIND_BAD_OP;
            end else begin
                nxt_state.phase = wfd_pkg::PH_HDR1;
            end
        end else begin
            case (cur_state.phase)
                wfd_pkg::PH_HDR1: begin
                    nxt_state.mask_present = stream_byte[7];
                    if (len7 == wfd_pkg::LEN7_EXT64) begin
                        nxt_state.phase    = wfd_pkg::PH_DONE;
                        result.valid       = 1'b1;
                        result.result_kind = wfd_pkg::KIND_LEN64;
                    end else if (len7 == wfd_pkg::LEN7_EXT16) begin
                        nxt_state.phase = wfd_pkg::PH_EXT_HI;
                    end else begin
                        nxt_state.frame_length = {9'd0, len7};
                        len_done               = 1'b1;
                    end
                end
                wfd_pkg::PH_EXT_HI: begin
                    nxt_state.frame_length = {stream_byte, 8'd0};
                    nxt_state.phase        = wfd_pkg::PH_EXT_LO;
                end
                wfd_pkg::PH_EXT_LO: begin
                    nxt_state.frame_length = {cur_state.frame_length[15:8], stream_byte};
                    len_done               = 1'b1;
                end
                wfd_pkg::PH_KEY: begin
                    case (cur_state.key_count)
                        2'd0:    nxt_state.mask_key[31:24] = stream_byte;
                        2'd1:    nxt_state.mask_key[23:16] = stream_byte;
                        2'd2:    nxt_state.mask_key[15:8]  = stream_byte;
                        default: nxt_state.mask_key[7:0]   = stream_byte;
                    endcase
                    nxt_state.key_count = cur_state.key_count + 2'd1;
                    hdr_done            = (cur_state.key_count == 2'd3);
                end
                wfd_pkg::PH_PAYLOAD: begin
                    if (cur_state.mask_present) begin
                        case (cur_state.payload_index[1:0])
                            2'd0:    key_byte = cur_state.mask_key[31:24];
                            2'd1:    key_byte = cur_state.mask_key[23:16];
                            2'd2:    key_byte = cur_state.mask_key[15:8];
                            default: key_byte = cur_state.mask_key[7:0];
                        endcase
                    end
                    nxt_state.payload_index = index_inc;
                    result.valid            = 1'b1;
                    result.payload_byte     = stream_byte ^ key_byte;
                    result.result_kind      = wfd_pkg::KIND_PAYLOAD;
                    if (index_inc >= cur_state.frame_length) begin
                        result.last_byte = 1'b1;
                        nxt_state.phase  = wfd_pkg::PH_DONE;
                    end
                end
                default: begin
                    // idle or finished: word dropped
                end
            endcase

            // Length complete: collect the key first when the frame is masked.
            if (len_done) begin
                if (nxt_state.mask_present) begin
                    nxt_state.key_count = '0;
                    nxt_state.mask_key  = '0;
                    nxt_state.phase     = wfd_pkg::PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                if (nxt_state.frame_length == 16'd0) begin
                    nxt_state.phase    = wfd_pkg::PH_DONE;
                    result.valid       = 1'b1;
                    result.last_byte   = 1'b1;
                    result.result_kind = wfd_pkg::KIND_EMPTY;
                end else begin
                    nxt_state.payload_index = '0;
                    nxt_state.phase         = wfd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* test/tb_websocket_frame_deframer.sv */
// Self-checking testbench for websocket_frame_deframer: directed and random
// frame streams, APB opcode changes between phases, scoreboard on m_ side.
// Depends on wfd_pkg and the websocket_frame_deframer RTL.
`default_nettype none

module tb_websocket_frame_deframer;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // one word on the s_ side
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } in_word_t;

    // one decoded word on the m_ side
    typedef struct packed {
        logic [7:0] payload;
        logic       last;
        logic [1:0] kind;
    } out_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    websocket_frame_deframer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus queue (filled by the sequencer) and decoded words still owed.
    in_word_t    pending_words[$];
    out_word_t   due_words[$];
    int unsigned phase_words;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;     // chance of an s_ gap after each word
    int unsigned stall_pct = 0;    // chance of an m_ stall burst
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    // Shadow of the parser and of the opcode register.
    wfd_pkg::phase_t ph;
    logic [15:0]     flen;
    logic [15:0]     pidx;
    logic [31:0]     key;
    logic            masked;
    logic [1:0]      kcnt;
    logic [3:0]      opcode_copy;

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", msg);
    endtask

    task automatic add_due(input logic [7:0] p, input logic l, input logic [1:0] k);
        out_word_t w;
        w.payload = p;
        w.last    = l;
        w.kind    = k;
        due_words.push_back(w);
    endtask

    // Length and key complete: empty marker or move on to payload.
    task automatic close_header();
        if (flen == 16'd0) begin
            ph = wfd_pkg::PH_DONE;
            add_due(8'h00, 1'b1, wfd_pkg::KIND_EMPTY);
        end else begin
            pidx = 16'd0;
            ph   = wfd_pkg::PH_PAYLOAD;
        end
    endtask

    task automatic after_length();
        if (masked) begin
            kcnt = 2'd0;
            key  = 32'd0;
            ph   = wfd_pkg::PH_KEY;
        end else begin
            close_header();
        end
    endtask

    // Advance the shadow parser by one accepted word, queueing any result.
    task automatic decode_word(input logic [7:0] b, input logic rs);
        logic [1:0] n;
        logic [7:0] k;
        if (rs) begin
            // restart always wins, even mid-frame
            flen   = 16'd0;
            pidx   = 16'd0;
            key    = 32'd0;
            masked = 1'b0;
            kcnt   = 2'd0;
            if (b[3:0] != opcode_copy) begin
                ph = wfd_pkg::PH_DONE;
                add_due(8'h00, 1'b0, wfd_pkg::KIND_BAD_OP);
            end else begin
                ph = wfd_pkg::PH_HDR1;
            end
        end else begin
            case (ph)
                wfd_pkg::PH_HDR1: begin
                    masked = b[7];
                    if (b[6:0] == wfd_pkg::LEN7_EXT64) begin
                        ph = wfd_pkg::PH_DONE;
                        add_due(8'h00, 1'b0, wfd_pkg::KIND_LEN64);
                    end else if (b[6:0] == wfd_pkg::LEN7_EXT16) begin
                        ph = wfd_pkg::PH_EXT_HI;
                    end else begin
                        flen = {9'd0, b[6:0]};
                        after_length();
                    end
                end
                wfd_pkg::PH_EXT_HI: begin
                    flen = {b, 8'h00};
                    ph   = wfd_pkg::PH_EXT_LO;
                end
                wfd_pkg::PH_EXT_LO: begin
                    // no range check: short extended lengths pass as given
                    flen = flen | {8'h00, b};
                    after_length();
                end
                wfd_pkg::PH_KEY: begin
                    // first key byte lands in [31:24]
                    n    = kcnt;
                    key  = key | ({24'd0, b} << (24 - 8 * n));
                    kcnt = n + 2'd1;
                    if (n == 2'd3)
                        close_header();
                end
                wfd_pkg::PH_PAYLOAD: begin
                    k = masked ? 8'(key >> (24 - 8 * pidx[1:0])) : 8'h00;
                    pidx = pidx + 16'd1;
                    add_due(b ^ k, pidx >= flen, wfd_pkg::KIND_PAYLOAD);
                    if (pidx >= flen)
                        ph = wfd_pkg::PH_DONE;
                end
                default: ;   // idle or done: ignored until restart
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // s_ driver: one word per handshake, random gap bursts between words
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : s_drive
        in_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the word until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            s_tdata  <= w.data;
            s_tuser  <= w.restart;
            s_tvalid <= 1'b1;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                gap_left = $urandom_range(1, 9);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // m_ ready: random stall bursts
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check the m_ word first, then predict from the s_ word.
    // A result never shows up in the cycle its input is taken, so this
    // order keeps the fresh prediction out of the compare.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    flag_error($sformatf("unexpected word data=%02h last=%0b kind=%0d",
                                         m_tdata, m_tlast, m_tuser));
                end else begin
                    want = due_words.pop_front();
                    if (m_tdata !== want.payload || m_tlast !== want.last ||
                        m_tuser !== want.kind)
                        flag_error($sformatf(
                            "exp data=%02h last=%0b kind=%0d, got data=%02h last=%0b kind=%0d",
                            want.payload, want.last, want.kind, m_tdata, m_tlast, m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                decode_word(s_tdata, s_tuser[0]);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer helpers
    // ---------------------------------------------------------------
    task automatic queue_word(input logic [7:0] b, input logic rs);
        in_word_t w;
        w.data    = b;
        w.restart = rs;
        pending_words.push_back(w);
        phase_words++;
    endtask

    // Header (with random FIN/RSV nibble), optional extended length and key,
    // then 'sent' payload bytes: fewer than len cuts the frame, more trails it.
    task automatic queue_frame(input logic [3:0] op, input logic msk, input logic [15:0] len,
                               input logic ext, input int unsigned sent);
        queue_word({4'($urandom), op}, 1'b1);
        if (ext) begin
            queue_word({msk, wfd_pkg::LEN7_EXT16}, 1'b0);
            queue_word(len[15:8], 1'b0);
            queue_word(len[7:0], 1'b0);
        end else begin
            queue_word({msk, len[6:0]}, 1'b0);
        end
        if (msk)
            repeat (4) queue_word(8'($urandom), 1'b0);
        repeat (sent) queue_word(8'($urandom), 1'b0);
    endtask

    // Block is idle: nothing queued, nothing owed, pipeline flushed.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || due_words.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {wfd_pkg::REG_ACCEPTED_OPCODE, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;   // access cycle, pready is always high
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_opcode_readback();
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {28'd0, opcode_copy})
            flag_error($sformatf("opcode readback exp %08h got %08h",
                                 {28'd0, opcode_copy}, rd));
    endtask

    // Upper pwdata bits are random: the register keeps only the low nibble.
    task automatic set_opcode(input logic [3:0] op);
        logic [31:0] rd;
        apb_xfer(1'b1, {28'($urandom), op}, rd);
        opcode_copy = op;
        check_opcode_readback();
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // wrong opcodes, 64-bit lengths and cut or overlong frames.
    task automatic run_phase(input int unsigned n);
        int unsigned sel;
        int unsigned sent;
        logic [3:0]  op;
        logic        msk;
        logic        ext;
        logic [15:0] len;
        phase_words = 0;
        while (phase_words < n) begin
            sel = $urandom_range(0, 99);
            op  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : opcode_copy;
            msk = 1'($urandom);
            ext = 1'b0;
            if (sel < 60) begin
                len = 16'($urandom_range(0, 12));
            end else if (sel < 70) begin
                len = 16'($urandom_range(13, 125));
            end else if (sel < 81) begin
                ext = 1'b1;
                len = 16'($urandom_range(0, 200));
            end else begin
                len = 16'd0;
            end
            case ($urandom_range(0, 9))
                0:       sent = $urandom_range(0, len);
                1:       sent = len + $urandom_range(1, 3);
                default: sent = len;
            endcase
            if (sel >= 78 && sel < 81) begin
                // huge extended length, frame cut short
                len  = 16'($urandom);
                sent = $urandom_range(0, 6);
            end
            if (sel < 81) begin
                queue_frame(op, msk, len, ext, sent);
            end else if (sel < 86) begin
                queue_word({4'($urandom), op}, 1'b1);
                queue_word({msk, wfd_pkg::LEN7_EXT64}, 1'b0);
                repeat ($urandom_range(0, 2)) queue_word(8'($urandom), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) queue_word(8'($urandom), 1'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        ph          = wfd_pkg::PH_IDLE;
        flen        = 16'd0;
        pidx        = 16'd0;
        key         = 32'd0;
        masked      = 1'b0;
        kcnt        = 2'd0;
        opcode_copy = wfd_pkg::OPCODE_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        check_opcode_readback();

        // directed words, reset opcode (text)
        idle_pct  = 20;
        stall_pct = 20;
        queue_word(8'hFF, 1'b0);            // idle after reset: ignored
        queue_word(8'h00, 1'b0);
        queue_word(8'hF0, 1'b1);            // wrong opcode
        queue_word(8'h82, 1'b0);            // ignored after rejection
        queue_frame(wfd_pkg::OPCODE_RESET, 1'b0, 16'd0, 1'b0, 0);   // empty frame
        queue_frame(wfd_pkg::OPCODE_RESET, 1'b1, 16'd0, 1'b0, 0);   // empty, masked
        queue_word(8'h81, 1'b1);            // 64-bit length
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);            // ignored after rejection
        queue_frame(wfd_pkg::OPCODE_RESET, 1'b0, 16'd5, 1'b0, 2);   // cut by next restart
        queue_frame(wfd_pkg::OPCODE_RESET, 1'b1, 16'd2, 1'b0, 3);   // masked, trailing byte
        queue_frame(wfd_pkg::OPCODE_RESET, 1'b0, 16'd1, 1'b1, 1);   // short extended length
        wait_drained();

        set_opcode(4'h0);
        idle_pct  = 30;
        stall_pct = 15;
        run_phase(240);
        wait_drained();

        set_opcode(4'hF);
        idle_pct  = 10;
        stall_pct = 40;
        run_phase(240);
        wait_drained();

        set_opcode(4'($urandom));
        idle_pct  = 50;
        stall_pct = 5;
        run_phase(240);
        wait_drained();

        // last part at full rate on both sides
        set_opcode(wfd_pkg::OPCODE_RESET);
        idle_pct  = 0;
        stall_pct = 0;
        run_phase(230);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (due_words.size() != 0)
            flag_error($sformatf("%0d decoded words never arrived", due_words.size()));
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
